[hdl/mf_pkg.sv]
`timescale 1ns / 1ps
package mf_pkg;

  localparam int COUNT_WIDTH = 12;
  localparam int MOD_WIDTH   = 16;
  localparam int PROD_WIDTH  = COUNT_WIDTH + MOD_WIDTH;
  // remainder unit retires two product bits per cycle
  localparam int RED_STEPS   = (PROD_WIDTH + 1) / 2;
  localparam int SH_WIDTH    = 2 * RED_STEPS;
  localparam int RED_CNT_W   = $clog2(RED_STEPS + 1);
  localparam int CMP_WIDTH   = (COUNT_WIDTH > MOD_WIDTH) ? COUNT_WIDTH : MOD_WIDTH;

  typedef enum logic [2:0] {
    STEP_WAIT,
    STEP_CHECK,
    STEP_TEST,
    STEP_MUL,
    STEP_RED,
    STEP_NEXT,
    STEP_ZERO,
    STEP_EMIT
  } step_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_MUL,
    OP_RED,
    OP_NEXT,
    OP_ZERO,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_REQ,
    COND_TRIVIAL,
    COND_I_GT_K,
    COND_RED_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t tgt;
    step_t nxt;
  } ucode_t;

  // datapath strobes, already qualified by the handshakes
  typedef struct packed {
    logic load;
    logic mul;
    logic red;
    logic next;
    logic zero;
    logic emit;
    logic ready;
  } mf_ctl_t;

  typedef struct packed {
    logic trivial;
    logic i_gt_k;
    logic red_more;
  } mf_stat_t;

  typedef struct packed {
    mf_stat_t dp;
    logic     in_valid;
    logic     out_busy;
  } mf_flags_t;

  // control store
  function automatic ucode_t mf_rom(step_t s);
    ucode_t w;
    w = '{op: OP_NOP, cond: COND_NEVER, tgt: STEP_WAIT, nxt: STEP_WAIT};
    unique case (s)
      STEP_WAIT:  w = '{op: OP_LOAD, cond: COND_NO_REQ,   tgt: STEP_WAIT, nxt: STEP_CHECK};
      STEP_CHECK: w = '{op: OP_NOP,  cond: COND_TRIVIAL,  tgt: STEP_ZERO, nxt: STEP_TEST};
      STEP_TEST:  w = '{op: OP_NOP,  cond: COND_I_GT_K,   tgt: STEP_EMIT, nxt: STEP_MUL};
      STEP_MUL:   w = '{op: OP_MUL,  cond: COND_NEVER,    tgt: STEP_WAIT, nxt: STEP_RED};
      STEP_RED:   w = '{op: OP_RED,  cond: COND_RED_MORE, tgt: STEP_RED,  nxt: STEP_NEXT};
      STEP_NEXT:  w = '{op: OP_NEXT, cond: COND_ALWAYS,   tgt: STEP_TEST, nxt: STEP_TEST};
      STEP_ZERO:  w = '{op: OP_ZERO, cond: COND_NEVER,    tgt: STEP_WAIT, nxt: STEP_EMIT};
      STEP_EMIT:  w = '{op: OP_EMIT, cond: COND_OUT_BUSY, tgt: STEP_EMIT, nxt: STEP_WAIT};
      default:    w = '{op: OP_NOP,  cond: COND_NEVER,    tgt: STEP_WAIT, nxt: STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

[hdl/mf_if.sv]
`timescale 1ns / 1ps
interface mf_req_if import mf_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] count;
  modport source (output valid, output count, input ready);
  modport sink (input valid, input count, output ready);
endinterface

interface mf_rsp_if import mf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] remainder_value;
  modport source (output valid, output remainder_value, input ready);
  modport sink (input valid, input remainder_value, output ready);
endinterface

interface mf_cfg_if import mf_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [MOD_WIDTH-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hdl/mf_sequencer.sv]
`timescale 1ns / 1ps
module mf_sequencer import mf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  mf_flags_t flags,
  output mf_ctl_t   ctl
);

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   jump;

  assign word = mf_rom(step);

  always_comb begin
    unique case (word.cond)
      COND_NEVER:    jump = 1'b0;
      COND_ALWAYS:   jump = 1'b1;
      COND_NO_REQ:   jump = !flags.in_valid;
      COND_TRIVIAL:  jump = flags.dp.trivial;
      COND_I_GT_K:   jump = flags.dp.i_gt_k;
      COND_RED_MORE: jump = flags.dp.red_more;
      COND_OUT_BUSY: jump = flags.out_busy;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    step_next = jump ? word.tgt : word.nxt;
  end

  always_comb begin
    ctl = '0;
    unique case (word.op)
      OP_NOP:  ctl = '0;
      OP_LOAD: begin
        ctl.ready = 1'b1;
        ctl.load  = flags.in_valid;
      end
      OP_MUL:  ctl.mul  = 1'b1;
      OP_RED:  ctl.red  = 1'b1;
      OP_NEXT: ctl.next = 1'b1;
      OP_ZERO: ctl.zero = 1'b1;
      OP_EMIT: ctl.emit = !flags.out_busy;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

endmodule

[hdl/mf_datapath.sv]
`timescale 1ns / 1ps
module mf_datapath import mf_pkg::*; (
  input  logic                   clk,
  input  mf_ctl_t                ctl,
  input  logic [COUNT_WIDTH-1:0] count,
  input  logic [MOD_WIDTH-1:0]   modulus,
  output mf_stat_t               stat,
  output logic [MOD_WIDTH-1:0]   acc
);

  logic [COUNT_WIDTH-1:0] k;
  logic [COUNT_WIDTH:0]   i;
  logic [SH_WIDTH-1:0]    sh;
  logic [MOD_WIDTH-1:0]   rem;
  logic [RED_CNT_W-1:0]   cnt;
  logic [MOD_WIDTH-1:0]   rem_mid;
  logic [MOD_WIDTH-1:0]   rem_step;

  // one restoring step: shift in a product bit, subtract m if it fits
  function automatic logic [MOD_WIDTH-1:0] rstep(
    input logic [MOD_WIDTH-1:0] r,
    input logic                 b,
    input logic [MOD_WIDTH-1:0] m
  );
    logic [MOD_WIDTH:0] t;
    t = {r, b};
    if (t >= {1'b0, m}) begin
      t = t - {1'b0, m};
    end
    return t[MOD_WIDTH-1:0];
  endfunction

  assign rem_mid  = rstep(rem, sh[SH_WIDTH-1], modulus);
  assign rem_step = rstep(rem_mid, sh[SH_WIDTH-2], modulus);

  assign stat.trivial  = (modulus < MOD_WIDTH'(2)) ||
                         (CMP_WIDTH'(k) >= CMP_WIDTH'(modulus));
  assign stat.i_gt_k   = i > {1'b0, k};
  assign stat.red_more = cnt != RED_CNT_W'(1);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      k   <= count;
      acc <= MOD_WIDTH'(1);
      i   <= (COUNT_WIDTH + 1)'(2);
    end
    if (ctl.mul) begin
      // i never exceeds k inside the loop, so its low bits suffice
      sh  <= SH_WIDTH'(acc) * SH_WIDTH'(i[COUNT_WIDTH-1:0]);
      rem <= '0;
      cnt <= RED_CNT_W'(RED_STEPS);
    end
    if (ctl.red) begin
      rem <= rem_step;
      sh  <= sh << 2;
      cnt <= cnt - RED_CNT_W'(1);
    end
    if (ctl.next) begin
      acc <= rem;
      i   <= i + (COUNT_WIDTH + 1)'(1);
    end
    if (ctl.zero) begin
      acc <= '0;
    end
  end

endmodule

[hdl/modular_factorial.sv]
`timescale 1ns / 1ps
// channel  modport  beat payload
// cfg      sink     data: modulus, 16 bits unsigned, always ready
// req      sink     count: k, 12 bits unsigned
// rsp      source   remainder_value: k! mod m, 16 bits unsigned
//
// a beat with m > 1 and 0 < k < m loops over the factors 2 to k, where
// each factor costs one multiply, 14 remainder steps (two bits a cycle over
// the 28-bit product) and two sequencer steps; other beats, k of zero too, skip the loop
// one item at a time; the next request is taken once the result is in the
// output register, a stalled result holds the sequencer in its emit step
// rst is synchronous; it sets the modulus to 1 and clears the output valid
module modular_factorial import mf_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  mf_cfg_if.sink  cfg,
  mf_req_if.sink  req,
  mf_rsp_if.source rsp
);

  logic [MOD_WIDTH-1:0] modulus;
  logic                 out_valid;
  logic [MOD_WIDTH-1:0] out_data;
  logic [MOD_WIDTH-1:0] acc;
  mf_ctl_t              ctl;
  mf_stat_t             stat;
  mf_flags_t            flags;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_WIDTH'(1);
    end else if (cfg.valid) begin
      modulus <= cfg.data;
    end
  end

  assign flags.dp       = stat;
  assign flags.in_valid = req.valid;
  assign flags.out_busy = out_valid && !rsp.ready;

  mf_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  mf_datapath u_dp (
    .clk     (clk),
    .ctl     (ctl),
    .count   (req.count),
    .modulus (modulus),
    .stat    (stat),
    .acc     (acc)
  );

  assign req.ready = ctl.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.emit) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_data <= acc;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.remainder_value = out_data;

endmodule

[hdl/mf_checker.sv]
`timescale 1ns / 1ps
module mf_port_checker import mf_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [MOD_WIDTH-1:0] cfg_data,
  input logic                 req_valid,
  input logic                 req_ready,
  input logic                 rsp_valid,
  input logic                 rsp_ready,
  input logic [MOD_WIDTH-1:0] rsp_remainder_value
);

  logic [MOD_WIDTH-1:0] shadow_mod;

  always_ff @(posedge clk) begin
    if (rst) begin
      shadow_mod <= MOD_WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      shadow_mod <= cfg_data;
    end
  end

  // stalled result stays up
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_remainder_value))
    else $error("result changed while stalled");

  // a residue always lies below the modulus, and is zero for a degenerate modulus
  a_rsp_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> ((shadow_mod < MOD_WIDTH'(2)) ? (rsp_remainder_value == '0)
                                               : (rsp_remainder_value < shadow_mod)))
    else $error("result out of range for modulus");

  // the sequencer leaves its wait step right after taking a request
  a_req_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("second request taken back to back");

endmodule

bind modular_factorial mf_port_checker u_mf_checker (
  .clk                 (clk),
  .rst                 (rst),
  .cfg_valid           (cfg.valid),
  .cfg_ready           (cfg.ready),
  .cfg_data            (cfg.data),
  .req_valid           (req.valid),
  .req_ready           (req.ready),
  .rsp_valid           (rsp.valid),
  .rsp_ready           (rsp.ready),
  .rsp_remainder_value (rsp.remainder_value)
);
